// ===== design/dfrb_pkg.sv =====
// dfrb_pkg: shared types and codes of the delimited frame ring buffer
// operation, command, status and register index codes, payload structs
// no dependencies
package dfrb_pkg;

    // operation codes of an input word
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_FETCH = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // command kinds passed from front to back
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_FETCH = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // result status codes
    localparam logic [2:0] ST_ACCEPTED   = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_NO_FRAME   = 3'd2;
    localparam logic [2:0] ST_FRAME_BYTE = 3'd3;
    localparam logic [2:0] ST_EMPTY      = 3'd4;
    localparam logic [2:0] ST_CLEARED    = 3'd5;

    // configuration register indexes
    localparam logic [2:0] REG_RING_SIZE     = 3'd0;
    localparam logic [2:0] REG_START_PATTERN = 3'd1;
    localparam logic [2:0] REG_START_LENGTH  = 3'd2;
    localparam logic [2:0] REG_END_PATTERN   = 3'd3;
    localparam logic [2:0] REG_END_LENGTH    = 3'd4;

    // register reset values
    localparam logic [6:0] RING_SIZE_RST = 7'd64;
    localparam logic [2:0] LENGTH_RST    = 3'd1;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] frame_byte;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic [6:0]  ring_size;
        logic [31:0] start_pattern;
        logic [2:0]  start_length;
        logic [31:0] end_pattern;
        logic [2:0]  end_length;
    } t_cfg;

endpackage

// ===== design/delimited_frame_ring_buffer.sv =====
// delimited_frame_ring_buffer: top level, configuration registers and wiring
// instantiates dfrb_front and dfrb_back
// depends on dfrb_pkg
//
// usage:
//   a word is taken at a rising edge with start high and busy low; busy is
//   high while two commands wait in the front queue.
//   each result is shown for one cycle with o_res_strobe high; the receiver
//   cannot stall, so results are never held back.
//   push and clear give one result each, registered after the command leaves
//   the front queue while the back end is idle.
//   a fetch reads the held bytes one per cycle through the single ring read
//   port, first scanning for the delimiters; payload bytes then stream out
//   one per cycle, last marks the end.
//   configuration writes use i_cfg_valid / o_cfg_ready (always ready); the
//   user must make them only while the block is idle, which the block does
//   not enforce itself; a ring_size write restarts the pointers.
//   reset empties the ring and loads default registers; no clearing pass is
//   needed, the ring contents are only read once written.
module delimited_frame_ring_buffer #(
    parameter int RING_DEPTH          = 64,
    parameter int MAX_DELIMITER_BYTES = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  dfrb_pkg::t_in_item  i_item,
    output logic                busy,
    output logic                o_res_strobe,
    output dfrb_pkg::t_out_item o_result,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import dfrb_pkg::*;

    t_cfg   r_cfg;
    logic   cfg_wr;
    logic   cmd_valid;
    logic   cmd_pop;
    t_cmd   cmd;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ring_size     <= RING_SIZE_RST;
            r_cfg.start_pattern <= 32'd0;
            r_cfg.start_length  <= LENGTH_RST;
            r_cfg.end_pattern   <= 32'd0;
            r_cfg.end_length    <= LENGTH_RST;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                REG_RING_SIZE:     r_cfg.ring_size     <= i_cfg_data[6:0];
                REG_START_PATTERN: r_cfg.start_pattern <= i_cfg_data;
                REG_START_LENGTH:  r_cfg.start_length  <= i_cfg_data[2:0];
                REG_END_PATTERN:   r_cfg.end_pattern   <= i_cfg_data;
                REG_END_LENGTH:    r_cfg.end_length    <= i_cfg_data[2:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // front: accept and classify
    dfrb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_item      (i_item),
        .busy        (busy),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // back: ring, scan and emission
    dfrb_back #(
        .RING_DEPTH          (RING_DEPTH),
        .MAX_DELIMITER_BYTES (MAX_DELIMITER_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_ptr_clr    (cfg_wr && (i_cfg_index == REG_RING_SIZE)),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_pop    (cmd_pop),
        .o_res_strobe (o_res_strobe),
        .o_result     (o_result)
    );

endmodule

// ===== design/dfrb_front.sv =====
// dfrb_front: accepts input words, classifies the operation and queues commands
// two-entry command queue between the handshake and the executing back end
// depends on dfrb_pkg
module dfrb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  dfrb_pkg::t_in_item i_item,
    output logic              busy,
    output logic              o_cmd_valid,
    output dfrb_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_pop
);
    import dfrb_pkg::*;

    localparam int QD = 2;

    t_cmd       r_q [QD];
    logic       r_wr, n_wr;
    logic       r_rd, n_rd;
    logic [1:0] r_cnt, n_cnt;
    logic       push;
    t_cmd       cmd_in;

    // classify the operation, unused code runs as a fetch
    always_comb begin
        cmd_in.data = i_item.data_byte;
        unique case (i_item.operation)
            OP_PUSH:  cmd_in.kind = CMD_PUSH;
            OP_CLEAR: cmd_in.kind = CMD_CLEAR;
            default:  cmd_in.kind = CMD_FETCH;
        endcase
    end

    // queue pointers and fill count
    assign busy        = (r_cnt == 2'(QD));
    assign push        = start && !busy;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        n_wr  = push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_cmd_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + 2'(push) - 2'(i_cmd_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cmd_in;
        end
    end

endmodule

// ===== design/dfrb_back.sv =====
// dfrb_back: executes queued commands against the byte ring
// ring memory, pointers, delimiter scan and frame emission sequencer
// depends on dfrb_pkg
module dfrb_back #(
    parameter int RING_DEPTH          = 64,
    parameter int MAX_DELIMITER_BYTES = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dfrb_pkg::t_cfg      i_cfg,
    input  logic                i_ptr_clr,
    input  logic                i_cmd_valid,
    input  dfrb_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    output logic                o_res_strobe,
    output dfrb_pkg::t_out_item o_result
);
    import dfrb_pkg::*;

    localparam int PW = $clog2(RING_DEPTH);
    localparam int SW = PW + 1;
    localparam int LW = $clog2(MAX_DELIMITER_BYTES + 1);
    localparam int CW = $clog2(RING_DEPTH + MAX_DELIMITER_BYTES + 2) + 1;
    localparam int WW = 8 * MAX_DELIMITER_BYTES;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    // clamp a delimiter length to one up to the maximum
    function automatic logic [LW-1:0] clamp_len(input logic [2:0] v);
        logic [LW-1:0] r;
        if (v == 3'd0) begin
            r = LW'(1);
        end else if ({1'b0, v} > 4'(MAX_DELIMITER_BYTES)) begin
            r = LW'(MAX_DELIMITER_BYTES);
        end else begin
            r = LW'(v);
        end
        return r;
    endfunction

    // step a ring address, wrapping at the ring size
    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p,
                                              input logic [SW-1:0] sz);
        logic [SW-1:0] t;
        t = {1'b0, p} + SW'(1);
        return (t >= sz) ? '0 : t[PW-1:0];
    endfunction

    // window byte m is the byte m places before the newest one
    function automatic logic delim_match(input logic [WW-1:0] w,
                                         input logic [31:0] pat,
                                         input logic [LW-1:0] len);
        logic [63:0] p64;
        logic [2:0]  bi;
        logic        ok;
        p64 = {32'd0, pat};
        ok  = 1'b1;
        for (int m = 0; m < MAX_DELIMITER_BYTES; m++) begin
            bi = 3'(len - LW'(m) - LW'(1));
            if ((LW'(m) < len) && (w[8*m +: 8] != p64[{bi, 3'b000} +: 8])) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic t_out_item single_result(input logic [2:0] st);
        t_out_item r;
        r.status     = st;
        r.frame_byte = 8'd0;
        r.last       = 1'b1;
        return r;
    endfunction

    logic [7:0]    r_mem [RING_DEPTH];
    logic [7:0]    r_rd;
    logic [1:0]    r_state, n_state;
    logic [PW-1:0] r_rp, n_rp;
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_off, n_off;
    logic [PW-1:0] r_kend, n_kend;
    logic [PW-1:0] r_kaddr, n_kaddr;
    logic [PW-1:0] r_addr, n_addr;
    logic [PW-1:0] r_n, n_n;
    logic [WW-1:0] r_win, n_win;
    logic [LW-1:0] r_fill, n_fill;
    logic          r_phase, n_phase;
    logic          r_strobe, n_strobe;
    t_out_item     r_res, n_res;
    logic          mem_we;

    logic [SW-1:0] size;
    logic [LW-1:0] slen, elen;
    logic [SW-1:0] held;
    logic [CW-1:0] held_c, j1;
    logic [WW+7:0] wx;
    logic [WW-1:0] wv;
    logic [LW-1:0] fill_new;
    logic          full;
    logic          st_ok, st_last, en_ok, en_last;
    logic [PW-1:0] n_cnt;

    // effective configuration
    always_comb begin
        if (i_cfg.ring_size < 7'd2) begin
            size = SW'(2);
        end else if (i_cfg.ring_size > 7'(RING_DEPTH)) begin
            size = SW'(RING_DEPTH);
        end else begin
            size = SW'(i_cfg.ring_size);
        end
        slen = clamp_len(i_cfg.start_length);
        elen = clamp_len(i_cfg.end_length);
    end

    // fill level and full flag
    always_comb begin
        if (r_wp >= r_rp) begin
            held = {1'b0, r_wp} - {1'b0, r_rp};
        end else begin
            held = {1'b0, r_wp} + size - {1'b0, r_rp};
        end
        held_c = CW'(held);
        full   = (ptr_inc(r_wp, size) == r_rp);
    end

    // delimiter window and match conditions for the byte now read
    always_comb begin
        wx       = {r_win, r_rd};
        wv       = wx[WW-1:0];
        fill_new = (r_fill == LW'(MAX_DELIMITER_BYTES)) ? r_fill : r_fill + LW'(1);
        j1       = CW'(r_off) + CW'(1);
        st_ok    = (fill_new >= slen) && delim_match(wv, i_cfg.start_pattern, slen)
                   && (j1 + CW'(elen) <= held_c);
        st_last  = (j1 + CW'(1) + CW'(elen) > held_c);
        en_ok    = (fill_new >= elen) && delim_match(wv, i_cfg.end_pattern, elen);
        en_last  = (j1 >= held_c);
        n_cnt    = PW'(CW'(r_off) - CW'(elen) - CW'(r_kend));
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_rp      = r_rp;
        n_wp      = r_wp;
        n_off     = r_off;
        n_kend    = r_kend;
        n_kaddr   = r_kaddr;
        n_addr    = r_addr;
        n_n       = r_n;
        n_win     = r_win;
        n_fill    = r_fill;
        n_phase   = r_phase;
        n_strobe  = 1'b0;
        n_res     = r_res;
        mem_we    = 1'b0;
        o_cmd_pop = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.kind)
                        CMD_PUSH: begin
                            n_strobe = 1'b1;
                            if (full) begin
                                n_res = single_result(ST_FULL);
                            end else begin
                                mem_we = 1'b1;
                                n_wp   = ptr_inc(r_wp, size);
                                n_res  = single_result(ST_ACCEPTED);
                            end
                        end
                        CMD_CLEAR: begin
                            n_rp     = '0;
                            n_wp     = '0;
                            n_strobe = 1'b1;
                            n_res    = single_result(ST_CLEARED);
                        end
                        CMD_FETCH: begin
                            if (held_c < CW'(slen) + CW'(elen)) begin
                                n_strobe = 1'b1;
                                n_res    = single_result(ST_NO_FRAME);
                            end else begin
                                n_addr  = r_rp;
                                n_off   = '0;
                                n_fill  = '0;
                                n_phase = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_win  = wv;
                n_fill = fill_new;
                n_off  = r_off + PW'(1);
                n_addr = ptr_inc(r_addr, size);
                if (!r_phase) begin
                    // looking for the start delimiter
                    if (st_ok) begin
                        n_phase = 1'b1;
                        n_fill  = '0;
                        n_kend  = r_off;
                        n_kaddr = r_addr;
                    end else if (st_last) begin
                        n_strobe = 1'b1;
                        n_res    = single_result(ST_NO_FRAME);
                        n_state  = S_IDLE;
                    end
                end else begin
                    // looking for the end delimiter
                    if (en_ok) begin
                        n_rp = ptr_inc(r_addr, size);
                        if (n_cnt == '0) begin
                            n_strobe = 1'b1;
                            n_res    = single_result(ST_EMPTY);
                            n_state  = S_IDLE;
                        end else begin
                            n_n     = n_cnt;
                            n_addr  = ptr_inc(r_kaddr, size);
                            n_state = S_EMIT;
                        end
                    end else if (en_last) begin
                        n_strobe = 1'b1;
                        n_res    = single_result(ST_NO_FRAME);
                        n_state  = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                // one payload word per cycle
                n_strobe         = 1'b1;
                n_res.status     = ST_FRAME_BYTE;
                n_res.frame_byte = r_rd;
                n_res.last       = (r_n == PW'(1));
                n_n              = r_n - PW'(1);
                n_addr           = ptr_inc(r_addr, size);
                if (r_n == PW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // a ring size write restarts both pointers
        if (i_ptr_clr) begin
            n_rp = '0;
            n_wp = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rp     <= '0;
            r_wp     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rp     <= n_rp;
            r_wp     <= n_wp;
            r_strobe <= n_strobe;
        end
    end

    // scan and result payload registers
    always_ff @(posedge i_clk) begin
        r_off   <= n_off;
        r_kend  <= n_kend;
        r_kaddr <= n_kaddr;
        r_addr  <= n_addr;
        r_n     <= n_n;
        r_win   <= n_win;
        r_fill  <= n_fill;
        r_phase <= n_phase;
        r_res   <= n_res;
    end

    // ring memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wp] <= i_cmd.data;
        end
        r_rd <= r_mem[n_addr];
    end

    assign o_res_strobe = r_strobe;
    assign o_result     = r_res;

endmodule

// ===== bench/tb_delimited_frame_ring_buffer.sv =====
// tb_delimited_frame_ring_buffer: self-checking bench for the delimited frame ring buffer
// holds a shadow copy of the ring and its registers that predicts every result word
// depends on dfrb_pkg and delimited_frame_ring_buffer
`timescale 1ns / 100ps

import dfrb_pkg::*;

// shadow of the ring state; predicts result words and checks them in order
class frame_ring_shadow;
    logic [7:0]  ring_bytes [64];
    int          rd_ptr;
    int          wr_ptr;
    logic [6:0]  size_reg;
    logic [31:0] start_pat;
    logic [2:0]  start_len;
    logic [31:0] end_pat;
    logic [2:0]  end_len;
    t_out_item   due_results [$];
    int          n_mismatch;

    function new();
        foreach (ring_bytes[i]) ring_bytes[i] = 8'h00;
        rd_ptr     = 0;
        wr_ptr     = 0;
        size_reg   = RING_SIZE_RST;
        start_pat  = 32'h0;
        start_len  = LENGTH_RST;
        end_pat    = 32'h0;
        end_len    = LENGTH_RST;
        n_mismatch = 0;
    endfunction

    function int eff_size();
        int s;
        s = int'(size_reg);
        if (s < 2) s = 2;
        if (s > 64) s = 64;
        return s;
    endfunction

    function int eff_len(logic [2:0] len);
        int l;
        l = int'(len);
        if (l < 1) l = 1;
        if (l > 4) l = 4;
        return l;
    endfunction

    function int held_count();
        int s;
        s = eff_size();
        return (wr_ptr % s + s - rd_ptr % s) % s;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
        case (idx)
            REG_RING_SIZE: begin
                size_reg = data[6:0];
                rd_ptr   = 0;
                wr_ptr   = 0;
            end
            REG_START_PATTERN: start_pat = data;
            REG_START_LENGTH:  start_len = data[2:0];
            REG_END_PATTERN:   end_pat   = data;
            REG_END_LENGTH:    end_len   = data[2:0];
            default: ;
        endcase
    endfunction

    // byte held at an offset from the read pointer
    function logic [7:0] held_at(int offset, int s);
        return ring_bytes[6'((rd_ptr + offset) % s)];
    endfunction

    function bit delim_at(int offset, logic [31:0] pat, int len, int s);
        for (int i = 0; i < len; i++) begin
            if (held_at(offset + i, s) != pat[8*i +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function void add_result(logic [2:0] status, logic [7:0] data, logic last);
        t_out_item r;
        r.status     = status;
        r.frame_byte = data;
        r.last       = last;
        due_results.push_back(r);
    endfunction

    // note an accepted input word and queue the result words it causes
    function void take_word(t_in_item w);
        int  s;
        int  slen;
        int  elen;
        int  held;
        int  k;
        int  e;
        int  n;
        bit  found;
        s      = eff_size();
        rd_ptr = rd_ptr % s;
        wr_ptr = wr_ptr % s;
        case (w.operation)
            OP_PUSH: begin
                if ((wr_ptr + 1) % s == rd_ptr) begin
                    add_result(ST_FULL, 8'h00, 1'b1);
                end else begin
                    ring_bytes[6'(wr_ptr)] = w.data_byte;
                    wr_ptr = (wr_ptr + 1) % s;
                    add_result(ST_ACCEPTED, 8'h00, 1'b1);
                end
            end
            OP_CLEAR: begin
                rd_ptr = 0;
                wr_ptr = 0;
                add_result(ST_CLEARED, 8'h00, 1'b1);
            end
            default: begin
                // fetch: search start delimiter, then end delimiter past it
                slen  = eff_len(start_len);
                elen  = eff_len(end_len);
                held  = (wr_ptr + s - rd_ptr) % s;
                found = 1'b0;
                for (k = 0; k + slen + elen <= held; k++) begin
                    if (delim_at(k, start_pat, slen, s)) begin
                        found = 1'b1;
                        break;
                    end
                end
                if (found) begin
                    found = 1'b0;
                    for (e = k + slen; e + elen <= held; e++) begin
                        if (delim_at(e, end_pat, elen, s)) begin
                            found = 1'b1;
                            break;
                        end
                    end
                end
                if (!found) begin
                    add_result(ST_NO_FRAME, 8'h00, 1'b1);
                end else begin
                    n = e - (k + slen);
                    if (n == 0) begin
                        add_result(ST_EMPTY, 8'h00, 1'b1);
                    end else begin
                        for (int i = 0; i < n; i++)
                            add_result(ST_FRAME_BYTE, held_at(k + slen + i, s), i == n - 1);
                    end
                    rd_ptr = (rd_ptr + e + elen) % s;
                end
            end
        endcase
    endfunction

    // compare one result word with the oldest prediction
    function void check_word(t_out_item got);
        t_out_item want;
        if (due_results.size() == 0) begin
            if (n_mismatch < 10)
                $display("%0t: unexpected result status %0d byte %02h last %0d",
                         $time, got.status, got.frame_byte, got.last);
            n_mismatch++;
            return;
        end
        want = due_results.pop_front();
        if (got.status != want.status || got.frame_byte != want.frame_byte ||
            got.last != want.last) begin
            if (n_mismatch < 10)
                $display("%0t: mismatch, expected status %0d byte %02h last %0d, got %0d %02h %0d",
                         $time, want.status, want.frame_byte, want.last,
                         got.status, got.frame_byte, got.last);
            n_mismatch++;
        end
    endfunction
endclass

module tb_delimited_frame_ring_buffer;
    import dfrb_pkg::*;

    localparam int         CLK_PERIOD    = 8;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         END_CYCLES    = 20;
    localparam int         QUIET_LIMIT   = 3000;
    // unused operation code, handled as a fetch
    localparam logic [1:0] OP_FETCH_ALT  = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    t_in_item    in_word;
    logic        busy;
    logic        o_res_strobe;
    t_out_item   o_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    frame_ring_shadow shadow;
    int               words_sent;
    int               quiet_cycles;
    bit               no_gaps;

    delimited_frame_ring_buffer uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_item       (in_word),
        .busy         (busy),
        .o_res_strobe (o_res_strobe),
        .o_result     (o_result),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    // clock
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // result words are checked as they leave the block
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_strobe) shadow.check_word(o_result);
    end

    // count cycles with no handshake of any kind
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_strobe || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // send one word; called and returns at a falling edge
    task automatic send_word(logic [1:0] op, logic [7:0] data);
        t_in_item w;
        int       gap;
        w.operation = op;
        w.data_byte = data;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start   <= 1'b1;
        in_word <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        shadow.take_word(w);
        words_sent++;
        @(negedge i_clk);
    endtask

    // hold off until every predicted word has come out, then let the block go quiet
    task automatic settle();
        start <= 1'b0;
        while (shadow.due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        cfg_index   <= idx;
        cfg_data    <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(logic [6:0] slots, logic [31:0] spat, logic [2:0] slen,
                              logic [31:0] epat, logic [2:0] elen);
        settle();
        write_reg(REG_RING_SIZE, 32'(slots));
        write_reg(REG_START_PATTERN, spat);
        write_reg(REG_START_LENGTH, 32'(slen));
        write_reg(REG_END_PATTERN, epat);
        write_reg(REG_END_LENGTH, 32'(elen));
    endtask

    task automatic push_delim(logic [31:0] pat, int len);
        for (int i = 0; i < len; i++) send_word(OP_PUSH, pat[8*i +: 8]);
    endtask

    // one framed sequence with random payload; sometimes noisy or broken
    task automatic send_frame();
        int         slen;
        int         elen;
        int         room;
        int         n;
        int         shape;
        logic [7:0] b;
        slen = shadow.eff_len(shadow.start_len);
        elen = shadow.eff_len(shadow.end_len);
        room = shadow.eff_size() - 1 - slen - elen;
        if (room <= 0)
            n = 0;
        else if ($urandom_range(0, 7) == 0)
            n = $urandom_range(0, room);
        else
            n = $urandom_range(0, room < 5 ? room : 5);
        // make space most of the time, otherwise run into a full ring
        if (shadow.eff_size() - 1 - shadow.held_count() < n + slen + elen &&
            $urandom_range(0, 3) != 0)
            send_word(OP_CLEAR, 8'($urandom_range(0, 255)));
        // shape 0: noise in front, 1: start delimiter missing, 2: end delimiter missing
        shape = $urandom_range(0, 11);
        if (shape == 0 || $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3)) send_word(OP_PUSH, 8'($urandom_range(0, 255)));
        if (shape != 1) push_delim(shadow.start_pat, slen);
        for (int i = 0; i < n; i++) begin
            b = ($urandom_range(0, 5) == 0) ? shadow.end_pat[7:0]
                                            : 8'($urandom_range(0, 255));
            send_word(OP_PUSH, b);
        end
        if (shape != 2) push_delim(shadow.end_pat, elen);
        if ($urandom_range(0, 3) != 0)
            send_word(($urandom_range(0, 7) == 0) ? OP_FETCH_ALT : OP_FETCH,
                      8'($urandom_range(0, 255)));
        if ($urandom_range(0, 5) == 0) send_word(OP_FETCH, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 19) == 0) send_word(OP_CLEAR, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 24) == 0) settle();
    endtask

    task automatic random_phase(int count);
        int target;
        target = words_sent + count;
        while (words_sent < target) send_frame();
    endtask

    initial begin
        logic [31:0] same_pat;
        shadow       = new();
        words_sent   = 0;
        no_gaps      = 1'b0;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        in_word      = '0;
        i_cfg_valid  = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset registers, zero byte as both delimiters
        send_word(OP_FETCH, 8'h00);         // empty ring, no frame
        send_word(OP_PUSH, 8'h00);
        send_word(OP_PUSH, 8'hFF);
        send_word(OP_PUSH, 8'h00);
        send_word(OP_FETCH, 8'hFF);         // one payload byte
        send_word(OP_PUSH, 8'h00);
        send_word(OP_PUSH, 8'h00);
        send_word(OP_FETCH_ALT, 8'h00);     // empty payload through the spare code
        send_word(OP_FETCH_ALT, 8'hFF);     // nothing held
        send_word(OP_PUSH, 8'hA5);
        send_word(OP_PUSH, 8'h00);
        send_word(OP_FETCH, 8'h00);         // start delimiter not in reach
        send_word(OP_PUSH, 8'h5A);
        send_word(OP_FETCH, 8'h00);         // end delimiter missing
        send_word(OP_PUSH, 8'h00);
        send_word(OP_FETCH, 8'h00);         // frame found past leading junk
        send_word(OP_CLEAR, 8'hFF);
        // smallest ring holds a single byte
        settle();
        write_reg(REG_RING_SIZE, 32'd2);
        send_word(OP_PUSH, 8'h11);
        send_word(OP_PUSH, 8'h22);          // full
        send_word(OP_FETCH, 8'h00);
        send_word(OP_CLEAR, 8'h00);

        // random phases over several register settings
        no_gaps = 1'b1;
        set_config(7'd64, $urandom, 3'd4, $urandom, 3'd4);
        random_phase(40);
        no_gaps = 1'b0;
        set_config(7'd0, $urandom, 3'd0, $urandom, 3'd1);
        random_phase(15);
        set_config(7'd127, 32'hFFFF_FFFF, 3'd7, 32'h0000_0000, 3'd0);
        random_phase(40);
        no_gaps = ($urandom_range(0, 1) == 0);
        set_config(7'($urandom_range(5, 16)), $urandom, 3'($urandom_range(1, 4)),
                   $urandom, 3'($urandom_range(1, 4)));
        random_phase(40);
        no_gaps = 1'b0;
        set_config(7'($urandom_range(17, 63)), $urandom, 3'($urandom_range(0, 7)),
                   $urandom, 3'($urandom_range(0, 7)));
        random_phase(45);
        // same byte opens and closes a frame
        same_pat = $urandom;
        set_config(7'd64, same_pat, 3'd1, same_pat, 3'd1);
        random_phase(40);

        settle();
        repeat (END_CYCLES) @(posedge i_clk);
        if (shadow.n_mismatch == 0 && shadow.due_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== delimited_frame_ring_buffer.f =====
design/dfrb_pkg.sv
design/dfrb_front.sv
design/dfrb_back.sv
design/delimited_frame_ring_buffer.sv
bench/tb_delimited_frame_ring_buffer.sv
